>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the histogram checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HWB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("histogram assertion failed");

// next-cycle implication, disabled during reset
`define HWB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("histogram assertion failed");

`endif

>>> hdl/hwb_pkg.sv
// ----------------------------------------------------------------------------
// hwb_pkg
// Types and constants of the weighted histogram binning block.
// ----------------------------------------------------------------------------
package hwb_pkg;

  localparam int BIN_DEPTH = 1024;
  localparam int BIN_AW    = $clog2(BIN_DEPTH);
  localparam int COUNT_W   = 40;
  localparam int WEIGHT_W  = 32;
  localparam int IDX_W     = 32;
  localparam int LIMIT_W   = 11;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(BIN_DEPTH);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_DROP   = 2'd1,
    ST_NEG    = 2'd2,
    ST_READ   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_BINARY = 2'd1,
    REG_WEIGHT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] bin_limit;
    logic               binary_mode;
    logic               use_weights;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [BIN_AW-1:0] waddr;
    logic [COUNT_W-1:0] wdata;
    logic              re;
    logic [BIN_AW-1:0] raddr;
  } ram_req_t;

endpackage

>>> hdl/hwb_ram.sv
// ----------------------------------------------------------------------------
// hwb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hwb_ram #(
  parameter int Depth = 1024,
  parameter int Width = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/hwb_cfg.sv
// ----------------------------------------------------------------------------
// hwb_cfg
// APB register file: bin limit, binary mode and weight enable.
// ----------------------------------------------------------------------------
module hwb_cfg import hwb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t   cfg_q, cfg_d;
  logic   wr_en;
  reg_e   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[CFG_AW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LIMIT:  cfg_d.bin_limit   = pwdata[LIMIT_W-1:0];
        REG_BINARY: cfg_d.binary_mode = pwdata[0];
        REG_WEIGHT: cfg_d.use_weights = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LIMIT:  prdata = CFG_DW'(cfg_q.bin_limit);
      REG_BINARY: prdata = CFG_DW'(cfg_q.binary_mode);
      REG_WEIGHT: prdata = CFG_DW'(cfg_q.use_weights);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_limit   <= LIMIT_RST;
      cfg_q.binary_mode <= 1'b0;
      cfg_q.use_weights <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/hwb_core.sv
// ----------------------------------------------------------------------------
// hwb_core
// Clearing sweep, item decode, read-modify-write of one bin with forwarding.
// ----------------------------------------------------------------------------
module hwb_core import hwb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [IDX_W-1:0]    bin_index_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                read_last_i,
  output ram_req_t            ram_o,
  input  logic [COUNT_W-1:0]  ram_rdata_i,
  output logic                done_o,
  output logic [COUNT_W-1:0]  bin_count_o,
  output logic [1:0]          status_o,
  output logic                error_seen_o
);

  localparam logic [COUNT_W-1:0] CNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic [COUNT_W-1:0] CNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);

  // clearing sweep
  logic              clr_act_q;
  logic [BIN_AW-1:0] clr_cnt_q;

  // stage 1 (memory data valid)
  logic                s1_vld_q, s1_upd_q, s1_rd_q, s1_last_q, s1_neg_q;
  logic [BIN_AW-1:0]   s1_addr_q;
  logic [WEIGHT_W-1:0] s1_wt_q;
  status_e             s1_st_q;

  // write-back forwarding
  logic               fwd_vld_q;
  logic [BIN_AW-1:0]  fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;

  logic               flag_q, flag_d;
  logic               done_q;
  logic [COUNT_W-1:0] count_q;
  status_e            st_q;
  logic               err_q;

  logic               accept, neg, in_lim, rd_ok;
  logic [LIMIT_W-1:0] lim_eff;
  status_e            st_in;
  logic [COUNT_W-1:0] old_val, inc, new_val, wr_val;
  logic [COUNT_W:0]   sum;
  logic               wr_en;

  assign busy   = clr_act_q;
  assign accept = start & ~clr_act_q;

  assign lim_eff = (cfg_i.bin_limit > LIMIT_RST) ? LIMIT_RST : cfg_i.bin_limit;
  assign neg     = bin_index_i[IDX_W-1];
  assign in_lim  = ~neg & (bin_index_i < IDX_W'(lim_eff));
  assign rd_ok   = ~neg & (bin_index_i < IDX_W'(BIN_DEPTH));

  always_comb begin
    if (kind_i) begin
      st_in = ST_READ;
    end else if (neg) begin
      st_in = ST_NEG;
    end else if (in_lim) begin
      st_in = ST_ACCEPT;
    end else begin
      st_in = ST_DROP;
    end
  end

  assign old_val = (fwd_vld_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata_i;
  assign inc     = cfg_i.use_weights ? COUNT_W'(signed'(s1_wt_q)) : CNT_ONE;
  assign sum     = {old_val[COUNT_W-1], old_val} + {inc[COUNT_W-1], inc};

  always_comb begin
    if (cfg_i.binary_mode) begin
      new_val = CNT_ONE;
    end else if (sum[COUNT_W] != sum[COUNT_W-1]) begin
      new_val = sum[COUNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      new_val = sum[COUNT_W-1:0];
    end
  end

  assign wr_val = s1_rd_q ? '0 : new_val;
  assign wr_en  = s1_vld_q & (s1_upd_q | s1_rd_q);

  always_comb begin
    flag_d = flag_q;
    if (s1_vld_q) begin
      if (s1_neg_q) begin
        flag_d = 1'b1;
      end else if (s1_st_q == ST_READ && s1_last_q) begin
        flag_d = 1'b0;
      end
    end
  end

  always_comb begin
    ram_o.re    = accept;
    ram_o.raddr = bin_index_i[BIN_AW-1:0];
    if (clr_act_q) begin
      ram_o.we    = 1'b1;
      ram_o.waddr = clr_cnt_q;
      ram_o.wdata = '0;
    end else begin
      ram_o.we    = wr_en;
      ram_o.waddr = s1_addr_q;
      ram_o.wdata = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      flag_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (clr_act_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == BIN_AW'(BIN_DEPTH - 1)) begin
          clr_act_q <= 1'b0;
        end
      end
      s1_vld_q  <= accept;
      fwd_vld_q <= wr_en;
      flag_q    <= flag_d;
      done_q    <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_upd_q  <= ~kind_i & in_lim;
      s1_rd_q   <= kind_i & rd_ok;
      s1_neg_q  <= ~kind_i & neg;
      s1_last_q <= read_last_i;
      s1_addr_q <= bin_index_i[BIN_AW-1:0];
      s1_wt_q   <= weight_i;
      s1_st_q   <= st_in;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wr_val;
    end
    if (s1_vld_q) begin
      count_q <= s1_rd_q ? old_val : '0;
      st_q    <= s1_st_q;
      err_q   <= (s1_st_q == ST_READ) ? flag_q : flag_d;
    end
  end

  assign done_o       = done_q;
  assign bin_count_o  = count_q;
  assign status_o     = st_q;
  assign error_seen_o = err_q;

endmodule

>>> hdl/weighted_histogram_binning_top.sv
// ----------------------------------------------------------------------------
// weighted_histogram_binning_top
// Weighted histogram store with saturating bins, read-and-clear and APB setup.
// ----------------------------------------------------------------------------
// After reset, busy stays high while a sweep writes every bin to zero; APB
// writes are taken throughout. From then on busy is low and one item may be
// started every cycle. Each item yields one result, shown on done_o for a
// single cycle; its start is registered in s1_vld_q and then in done_q, and
// the receiver cannot stall it. Each item passes the registered read of the
// bin RAM, then the saturating update and write-back; a hit on the bin
// written in the previous cycle takes its value from the write-back register.
module weighted_histogram_binning_top import hwb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [IDX_W-1:0]    bin_index_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                read_last_i,
  output logic                done_o,
  output logic [COUNT_W-1:0]  bin_count_o,
  output logic [1:0]          status_o,
  output logic                error_seen_o
);

  cfg_t               cfg;
  ram_req_t           ram_req;
  logic [COUNT_W-1:0] ram_rdata;

  hwb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hwb_ram #(
    .Depth (BIN_DEPTH),
    .Width (COUNT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  hwb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .bin_index_i  (bin_index_i),
    .weight_i     (weight_i),
    .read_last_i  (read_last_i),
    .ram_o        (ram_req),
    .ram_rdata_i  (ram_rdata),
    .done_o       (done_o),
    .bin_count_o  (bin_count_o),
    .status_o     (status_o),
    .error_seen_o (error_seen_o)
  );

endmodule

>>> hdl/hwb_checker.sv
// ----------------------------------------------------------------------------
// hwb_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hwb_checker import hwb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [COUNT_W-1:0] bin_count_o,
  input logic [1:0]         status_o,
  input logic               error_seen_o
);

  `HWB_ASSERT_NXT(a_result_follows, clk_i, rst_ni, start && !busy, ##1 done_o)
  `HWB_ASSERT_IMP(a_no_stray_result, clk_i, rst_ni, done_o, $past(start && !busy, 2))
  `HWB_ASSERT_IMP(a_quiet_while_busy, clk_i, rst_ni, busy, !done_o)
  `HWB_ASSERT_IMP(a_sample_zero, clk_i, rst_ni, done_o && status_o != ST_READ, bin_count_o == '0)
  `HWB_ASSERT_IMP(a_neg_flags, clk_i, rst_ni, done_o && status_o == ST_NEG, error_seen_o)

endmodule

bind weighted_histogram_binning_top hwb_checker u_hwb_checker (.*);
